// File: hw/rtl/k_core_h_index_update_macros.svh
// Assertion macros used by the checker file of the k-core update block.
`ifndef K_CORE_H_INDEX_UPDATE_MACROS_SVH
`define K_CORE_H_INDEX_UPDATE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define KCH_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kch check failed");

// Next-cycle implication, checked outside reset.
`define KCH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kch check failed");

`endif

// File: hw/rtl/kch_pkg.sv
// Package: types, constants and helpers for the k-core h-index update block.
package kch_pkg;

   localparam int CORE_W         = 12;
   localparam int CNT_W          = 16;
   localparam int LIM_W          = 16;
   localparam int HIST_DEPTH     = 4096;
   localparam int HIST_AW        = $clog2(HIST_DEPTH);
   localparam int CORE_LIMIT_DEF = 4095;
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   typedef struct packed {
      logic [CORE_W-1:0] own_core;
      logic [CORE_W-1:0] neighbor_core;
      logic              neighbor_valid;
      logic              last;
   } req_word_type;

   typedef struct packed {
      logic [CORE_W-1:0] new_core;
      logic              changed;
   } rsp_word_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic               busy;
      logic               scan_issue;
      logic               clear_en;
      logic [HIST_AW-1:0] addr;
   } seq_ctrl_type;

   typedef struct packed {
      logic [HIST_AW-1:0] rd_addr;
      logic               wr_en;
      logic [HIST_AW-1:0] wr_addr;
      logic [CNT_W-1:0]   wr_data;
   } hist_cmd_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
      sat_inc = (x == CNT_MAX) ? CNT_MAX : x + CNT_W'(1);
   endfunction

endpackage

// File: hw/rtl/kch_hist_mem.sv
// Support histogram memory: one write and one registered read per cycle, with write forwarding.
module kch_hist_mem (
   input  logic                         clock,
   input  logic                         reset,
   input  kch_pkg::hist_cmd_type        cmd,
   output logic [kch_pkg::CNT_W-1:0]    rd_data
);

   logic [kch_pkg::CNT_W-1:0] mem [kch_pkg::HIST_DEPTH];
   logic [kch_pkg::CNT_W-1:0] rdata_ff;
   logic [kch_pkg::CNT_W-1:0] fwd_ff;
   logic                      hit_ff;
   logic                      hit_in;

   assign hit_in = cmd.wr_en && (cmd.wr_addr == cmd.rd_addr);

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      rdata_ff <= mem[cmd.rd_addr];
      fwd_ff   <= cmd.wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   assign rd_data = hit_ff ? fwd_ff : rdata_ff;

endmodule

// File: hw/rtl/kch_seq.sv
// Sequencer: reset clearing sweep, downward histogram scan and its address counter.
module kch_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept_last,
   input  logic [kch_pkg::HIST_AW-1:0]   load_addr,
   output kch_pkg::seq_ctrl_type         ctrl
);

   kch_pkg::state_type          state_ff, state_in;
   logic [kch_pkg::HIST_AW-1:0] cnt_ff, cnt_in;
   logic                        cnt_zero;

   assign cnt_zero = (cnt_ff == '0);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         kch_pkg::ST_CLEAR: begin
            cnt_in = cnt_ff - 1'b1;
            if (cnt_zero) begin
               state_in = kch_pkg::ST_IDLE;
            end
         end
         kch_pkg::ST_IDLE: begin
            if (accept_last) begin
               state_in = kch_pkg::ST_SCAN;
               cnt_in   = load_addr;
            end
         end
         kch_pkg::ST_SCAN: begin
            cnt_in = cnt_ff - 1'b1;
            if (cnt_zero) begin
               state_in = kch_pkg::ST_DRAIN;
            end
         end
         kch_pkg::ST_DRAIN: begin
            state_in = kch_pkg::ST_IDLE;
         end
         default: begin
            state_in = kch_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl.busy       = (state_ff != kch_pkg::ST_IDLE);
      ctrl.scan_issue = (state_ff == kch_pkg::ST_SCAN);
      ctrl.clear_en   = (state_ff == kch_pkg::ST_CLEAR);
      ctrl.addr       = cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kch_pkg::ST_CLEAR;
         cnt_ff   <= '1;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// File: hw/rtl/k_core_h_index_update.sv
// Top level: k-core estimate refinement of one vertex by the h-index rule.
//
//   channel | ports                   | handshake
//   req     | start, busy, req_word   | word taken when start && !busy
//   rsp     | rsp_valid, rsp_word     | word shown one cycle, always taken
//
// Neighbor words are taken one per clock while busy is low; each valid one does a
// read-modify-write of the histogram, with forwarding between back-to-back words.
// After the last word (est = latched estimate) busy stays high while the read port
// scans bins est..0, one per cycle, and the write port zeroes them on the way.
// The result shows in the first cycle with busy low again.
// After reset busy is high while the histogram is swept to zero.
module k_core_h_index_update #(
   parameter int CORE_LIMIT = kch_pkg::CORE_LIMIT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  kch_pkg::req_word_type  req_word,
   output logic                   rsp_valid,
   output kch_pkg::rsp_word_type  rsp_word
);

   localparam logic [kch_pkg::LIM_W-1:0] LIM = kch_pkg::LIM_W'(CORE_LIMIT);
   localparam int SUM_W = kch_pkg::CNT_W + 1;

   kch_pkg::seq_ctrl_type ctrl;
   kch_pkg::hist_cmd_type cmd;
   logic [kch_pkg::CNT_W-1:0] hist_val;

   logic                        accept;
   logic [kch_pkg::CORE_W-1:0]  capped;
   logic [kch_pkg::CORE_W-1:0]  est_now;
   logic [kch_pkg::HIST_AW-1:0] idx;

   logic                        in_run_ff, in_run_in;
   logic [kch_pkg::CORE_W-1:0]  est_ff, est_in;
   logic [kch_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [kch_pkg::CORE_W-1:0]  own_last_ff, own_last_in;
   logic                        item_v_ff, item_v_in;
   logic [kch_pkg::HIST_AW-1:0] item_idx_ff;
   logic                        scan_v_ff, scan_v_in;
   logic [kch_pkg::HIST_AW-1:0] scan_c_ff;
   logic [kch_pkg::CORE_W-1:0]  acc_ff, acc_in;
   logic                        found_ff, found_in;
   logic [kch_pkg::CORE_W-1:0]  res_ff, res_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   kch_pkg::rsp_word_type       rsp_word_ff, rsp_word_in;

   logic [SUM_W-1:0]            sum;
   logic                        stop;
   logic [kch_pkg::CORE_W-1:0]  final_core;

   assign busy   = ctrl.busy;
   assign accept = start && !ctrl.busy;

   assign capped  = ({{(kch_pkg::LIM_W-kch_pkg::CORE_W){1'b0}}, req_word.own_core} < LIM)
                    ? req_word.own_core : LIM[kch_pkg::CORE_W-1:0];
   assign est_now = in_run_ff ? est_ff : capped;
   assign idx     = kch_pkg::HIST_AW'((req_word.neighbor_core < est_now)
                    ? req_word.neighbor_core : est_now);

   kch_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .accept_last (accept && req_word.last),
      .load_addr   (kch_pkg::HIST_AW'(est_now)),
      .ctrl        (ctrl)
   );

   always_comb begin
      cmd.rd_addr = ctrl.busy ? ctrl.addr : idx;
      cmd.wr_en   = 1'b0;
      cmd.wr_addr = ctrl.addr;
      cmd.wr_data = '0;
      if (item_v_ff) begin
         cmd.wr_en   = 1'b1;
         cmd.wr_addr = item_idx_ff;
         cmd.wr_data = kch_pkg::sat_inc(hist_val);
      end else if (scan_v_ff) begin
         cmd.wr_en   = 1'b1;
         cmd.wr_addr = scan_c_ff;
      end else if (ctrl.clear_en) begin
         cmd.wr_en   = 1'b1;
      end
   end

   kch_hist_mem u_hist (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .rd_data (hist_val)
   );

   assign sum  = SUM_W'(acc_ff) + SUM_W'(hist_val);
   assign stop = (scan_c_ff == '0)
              || (sum >= SUM_W'(scan_c_ff))
              || ((kch_pkg::CORE_W'(scan_c_ff) == est_ff)
                  && (cnt_ff >= kch_pkg::CNT_W'(scan_c_ff)));
   assign final_core = found_ff ? res_ff : '0;

   always_comb begin
      in_run_in    = in_run_ff;
      est_in       = est_ff;
      cnt_in       = cnt_ff;
      own_last_in  = own_last_ff;
      item_v_in    = accept && req_word.neighbor_valid;
      scan_v_in    = ctrl.scan_issue;
      acc_in       = acc_ff;
      found_in     = found_ff;
      res_in       = res_ff;
      rsp_valid_in = 1'b0;
      rsp_word_in  = rsp_word_ff;
      if (accept) begin
         in_run_in = !req_word.last;
         est_in    = est_now;
         if (req_word.neighbor_valid && (req_word.neighbor_core >= est_now)) begin
            cnt_in = kch_pkg::sat_inc(cnt_ff);
         end
         if (req_word.last) begin
            own_last_in = req_word.own_core;
            acc_in      = '0;
            found_in    = 1'b0;
         end
      end
      if (scan_v_ff) begin
         if (!found_ff) begin
            if (stop) begin
               found_in = 1'b1;
               res_in   = kch_pkg::CORE_W'(scan_c_ff);
            end else begin
               acc_in = kch_pkg::CORE_W'(sum);
            end
         end
         if (scan_c_ff == '0) begin
            rsp_valid_in         = 1'b1;
            rsp_word_in.new_core = final_core;
            rsp_word_in.changed  = (final_core != own_last_ff);
            cnt_in               = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_run_ff    <= 1'b0;
         est_ff       <= '0;
         cnt_ff       <= '0;
         item_v_ff    <= 1'b0;
         scan_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_run_ff    <= in_run_in;
         est_ff       <= est_in;
         cnt_ff       <= cnt_in;
         item_v_ff    <= item_v_in;
         scan_v_ff    <= scan_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      own_last_ff <= own_last_in;
      item_idx_ff <= idx;
      scan_c_ff   <= ctrl.addr;
      acc_ff      <= acc_in;
      found_ff    <= found_in;
      res_ff      <= res_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// File: hw/rtl/kch_chk.sv
// Port-level checker for the k-core update block, bound to the top level.
`include "k_core_h_index_update_macros.svh"

module kch_chk (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input kch_pkg::req_word_type req_word,
   input logic                  rsp_valid
);

   // set by a taken last word, cleared when its result shows
   logic armed_ff, armed_in;

   always_comb begin
      armed_in = armed_ff;
      if (start && !busy && req_word.last) begin
         armed_in = 1'b1;
      end else if (rsp_valid) begin
         armed_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
      end else begin
         armed_ff <= armed_in;
      end
   end

   `KCH_ASSERT_NEXT(a_last_sets_busy, clock, reset, start && !busy && req_word.last, busy)
   `KCH_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   `KCH_ASSERT_NOW(a_rsp_after_busy, clock, reset, rsp_valid, $past(busy) && !busy)
   `KCH_ASSERT_NOW(a_busy_drop_rsp, clock, reset, $fell(busy) && armed_ff, rsp_valid)

endmodule

bind k_core_h_index_update kch_chk u_kch_chk (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_word  (req_word),
   .rsp_valid (rsp_valid)
);
